>>> hdl/sensor_fifo_drain_controller_top_defines.svh
// Assertion macros used by the checker file sfdc_checker.sv.
`ifndef SENSOR_FIFO_DRAIN_CONTROLLER_TOP_DEFINES_SVH
`define SENSOR_FIFO_DRAIN_CONTROLLER_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SFDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define SFDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/sfdc_pkg.sv
package sfdc_pkg;

	localparam int FIFO_DEPTH  = 32;
	localparam int COUNT_WIDTH = 16;
	localparam int PTR_W       = 5;
	localparam int VALUE_W     = 17;
	localparam int DIFF_W      = 7;

	localparam logic [7:0] ADDR_WPTR = 8'd4;
	localparam logic [7:0] ADDR_RPTR = 8'd6;
	localparam logic [7:0] ADDR_DATA = 8'd7;

	typedef enum logic [1:0] {
		MODE_TICK,
		MODE_BYTE,
		MODE_BUS_ERR,
		MODE_REJECT
	} mode_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_REFUSED,
		ACT_REG_READ,
		ACT_BURST,
		ACT_SAMPLE,
		ACT_EMPTY,
		ACT_ERROR
	} action_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] data_byte;
		logic       bus_ready;
	} event_t;

	typedef struct packed {
		action_t            action;
		logic [7:0]         reg_addr;
		logic [8:0]         burst_bytes;
		logic [VALUE_W-1:0] green_value;
		logic [VALUE_W-1:0] red_value;
		logic [VALUE_W-1:0] ir_value;
		logic               busy_flag;
		logic [15:0]        error_total;
		logic [15:0]        pointer_ok_total;
		logic [15:0]        empty_skip_total;
		logic [15:0]        burst_ok_total;
	} result_t;

	typedef logic [PTR_W-1:0] avail_lut_t [2**DIFF_W];

	// Index is the two's complement of wp + depth - rp; negative values
	// follow 32-bit unsigned wraparound.
	function automatic avail_lut_t build_avail_lut();
		avail_lut_t      lut;
		longint unsigned v;
		for (int i = 0; i < 2**DIFF_W; i++) begin
			if (i < 2**(DIFF_W-1)) begin
				v = 64'(i);
			end else begin
				v = 64'h1_0000_0000 - 64'(2**DIFF_W - i);
			end
			lut[i] = PTR_W'(v % FIFO_DEPTH);
		end
		return lut;
	endfunction

	localparam avail_lut_t AVAIL_LUT = build_avail_lut();

endpackage

>>> hdl/sfdc_event_if.sv
interface sfdc_event_if;
	logic              valid;
	logic              ready;
	sfdc_pkg::event_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/sfdc_result_if.sv
interface sfdc_result_if;
	logic              valid;
	logic              ready;
	sfdc_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/sfdc_core.sv
module sfdc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  sfdc_pkg::event_t  item,
	output sfdc_pkg::result_t result_q
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WPTR,
		PH_RPTR,
		PH_BURST
	} phase_t;

	phase_t phase_q, phase_d;
	logic [sfdc_pkg::PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
	logic [sfdc_pkg::PTR_W-1:0] pending_q, pending_d, done_q, done_d, done_inc;
	logic [3:0] pos_q, pos_d;
	logic [23:0] word_q, word_d, raw;
	logic [sfdc_pkg::VALUE_W-1:0] grn_q, grn_d, red_q, red_d;
	logic [sfdc_pkg::COUNT_WIDTH-1:0] err_q, err_d, ptr_q, ptr_d;
	logic [sfdc_pkg::COUNT_WIDTH-1:0] skip_q, skip_d, burst_q, burst_d;
	logic [sfdc_pkg::DIFF_W-1:0] diff;
	logic [sfdc_pkg::PTR_W-1:0] avail;
	sfdc_pkg::result_t res_d;

	assign diff = sfdc_pkg::DIFF_W'(wptr_q) + sfdc_pkg::DIFF_W'(sfdc_pkg::FIFO_DEPTH)
		- sfdc_pkg::DIFF_W'(item.data_byte[sfdc_pkg::PTR_W-1:0]);
	assign avail = sfdc_pkg::AVAIL_LUT[diff];
	assign raw = {word_q[15:0], item.data_byte};
	assign done_inc = done_q + 1'b1;

	always_comb begin
		phase_d   = phase_q;
		wptr_d    = wptr_q;
		rptr_d    = rptr_q;
		pending_d = pending_q;
		done_d    = done_q;
		pos_d     = pos_q;
		word_d    = word_q;
		grn_d     = grn_q;
		red_d     = red_q;
		err_d     = err_q;
		ptr_d     = ptr_q;
		skip_d    = skip_q;
		burst_d   = burst_q;
		res_d     = '0;
		res_d.action = sfdc_pkg::ACT_NONE;
		case (item.mode)
			sfdc_pkg::MODE_TICK: begin
				if (phase_q != PH_IDLE || !item.bus_ready) begin
					res_d.action = sfdc_pkg::ACT_REFUSED;
				end else begin
					phase_d = PH_WPTR;
					res_d.action = sfdc_pkg::ACT_REG_READ;
					res_d.reg_addr = sfdc_pkg::ADDR_WPTR;
				end
			end
			sfdc_pkg::MODE_BYTE: begin
				case (phase_q)
					PH_WPTR: begin
						wptr_d = item.data_byte[sfdc_pkg::PTR_W-1:0];
						phase_d = PH_RPTR;
						res_d.action = sfdc_pkg::ACT_REG_READ;
						res_d.reg_addr = sfdc_pkg::ADDR_RPTR;
					end
					PH_RPTR: begin
						rptr_d = item.data_byte[sfdc_pkg::PTR_W-1:0];
						ptr_d = ptr_q + 1'b1;
						pending_d = '0;
						done_d = '0;
						pos_d = '0;
						word_d = '0;
						grn_d = '0;
						red_d = '0;
						if (avail == '0) begin
							skip_d = skip_q + 1'b1;
							phase_d = PH_IDLE;
							res_d.action = sfdc_pkg::ACT_EMPTY;
						end else begin
							pending_d = avail;
							phase_d = PH_BURST;
							res_d.action = sfdc_pkg::ACT_BURST;
							res_d.reg_addr = sfdc_pkg::ADDR_DATA;
							res_d.burst_bytes = 9'({avail, 3'b000}) + 9'(avail);
						end
					end
					PH_BURST: begin
						if (pos_q == 4'd2) begin
							grn_d = raw[sfdc_pkg::VALUE_W:1];
							word_d = '0;
							pos_d = pos_q + 1'b1;
						end else if (pos_q == 4'd5) begin
							red_d = raw[sfdc_pkg::VALUE_W:1];
							word_d = '0;
							pos_d = pos_q + 1'b1;
						end else if (pos_q >= 4'd8) begin
							res_d.action = sfdc_pkg::ACT_SAMPLE;
							res_d.green_value = grn_q;
							res_d.red_value = red_q;
							res_d.ir_value = raw[sfdc_pkg::VALUE_W:1];
							word_d = '0;
							grn_d = '0;
							red_d = '0;
							pos_d = '0;
							done_d = done_inc;
							if (done_inc >= pending_q) begin
								burst_d = burst_q + 1'b1;
								phase_d = PH_IDLE;
								pending_d = '0;
								done_d = '0;
							end
						end else begin
							word_d = raw;
							pos_d = pos_q + 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
				if (item.mode == sfdc_pkg::MODE_BUS_ERR || phase_q != PH_IDLE) begin
					err_d = err_q + 1'b1;
					phase_d = PH_IDLE;
					pending_d = '0;
					done_d = '0;
					pos_d = '0;
					word_d = '0;
					grn_d = '0;
					red_d = '0;
					res_d.action = sfdc_pkg::ACT_ERROR;
				end
			end
		endcase
		res_d.busy_flag = (phase_d != PH_IDLE);
		res_d.error_total = 16'(err_d);
		res_d.pointer_ok_total = 16'(ptr_d);
		res_d.empty_skip_total = 16'(skip_d);
		res_d.burst_ok_total = 16'(burst_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			wptr_q    <= '0;
			rptr_q    <= '0;
			pending_q <= '0;
			done_q    <= '0;
			pos_q     <= '0;
			word_q    <= '0;
			grn_q     <= '0;
			red_q     <= '0;
			err_q     <= '0;
			ptr_q     <= '0;
			skip_q    <= '0;
			burst_q   <= '0;
			result_q  <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			wptr_q    <= wptr_d;
			rptr_q    <= rptr_d;
			pending_q <= pending_d;
			done_q    <= done_d;
			pos_q     <= pos_d;
			word_q    <= word_d;
			grn_q     <= grn_d;
			red_q     <= red_d;
			err_q     <= err_d;
			ptr_q     <= ptr_d;
			skip_q    <= skip_d;
			burst_q   <= burst_d;
			result_q  <= res_d;
		end
	end

endmodule

>>> hdl/sensor_fifo_drain_controller_top.sv
// channel   modport  payload             role
// events    sink     sfdc_pkg::event_t   poll ticks, bus bytes, errors
// results   source   sfdc_pkg::result_t  one result word per event word
//
// One event word accepted per cycle while events.ready is high; its result
// word passes the input register, then the state update into result_q.
// arst_n clears core state, counters and both valid flags, not item_s1.
// A stalled result word holds; events.ready drops only when both the input
// register and the result register are full.
module sensor_fifo_drain_controller_top (
	input logic           clk,
	input logic           arst_n,
	sfdc_event_if.sink    events,
	sfdc_result_if.source results
);

	logic             valid_s1;
	sfdc_pkg::event_t item_s1;
	logic             res_valid_q;
	logic             out_free;
	logic             step;

	assign out_free = !res_valid_q || results.ready;
	assign step = valid_s1 && out_free;
	assign events.ready = !valid_s1 || out_free;
	assign results.valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (events.ready) begin
				valid_s1 <= events.valid;
			end
			if (out_free) begin
				res_valid_q <= step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			item_s1 <= events.data;
		end
	end

	sfdc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item_s1),
		.result_q (results.data)
	);

endmodule

>>> hdl/sfdc_checker.sv
`include "sensor_fifo_drain_controller_top_defines.svh"

module sfdc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input sfdc_pkg::result_t res_data
);

	`SFDC_ASSERT_NEXT(a_result_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_data), "stalled result word changed")

	`SFDC_ASSERT_NOW(a_read_request, clk, arst_n, res_valid && res_data.action == sfdc_pkg::ACT_REG_READ, res_data.busy_flag && res_data.burst_bytes == 9'd0 && (res_data.reg_addr == sfdc_pkg::ADDR_WPTR || res_data.reg_addr == sfdc_pkg::ADDR_RPTR), "bad register read request")

	`SFDC_ASSERT_NOW(a_burst_request, clk, arst_n, res_valid && res_data.action == sfdc_pkg::ACT_BURST, res_data.busy_flag && res_data.reg_addr == sfdc_pkg::ADDR_DATA && res_data.burst_bytes != 9'd0, "bad burst request")

	`SFDC_ASSERT_NOW(a_back_to_idle, clk, arst_n, res_valid && (res_data.action == sfdc_pkg::ACT_ERROR || res_data.action == sfdc_pkg::ACT_EMPTY), !res_data.busy_flag && res_data.reg_addr == 8'd0 && res_data.burst_bytes == 9'd0, "error or skip left the block busy")

endmodule

bind sensor_fifo_drain_controller_top sfdc_checker u_sfdc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_data  (results.data)
);
